// ----- src/doppler_cross_correlation_monitor_defines.svh -----
// Assertion macros shared by the Doppler cross-correlation monitor RTL.
`ifndef DOPPLER_CROSS_CORRELATION_MONITOR_DEFINES_SVH
`define DOPPLER_CROSS_CORRELATION_MONITOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that the consequent holds in the same cycle as the antecedent.
`define DCCM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dccm: same-cycle check failed");
// Check that the consequent holds in the cycle after the antecedent.
`define DCCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dccm: next-cycle check failed");
`else
`define DCCM_ASSERT_SAME(lbl, ante, cons)
`define DCCM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/dccm_pkg.sv -----
// Package of widths, constants and types for the Doppler cross-correlation monitor.
`timescale 1ns / 1ps
`default_nettype none
package dccm_pkg;

    // Field widths
    localparam int F_W        = 24;
    localparam int CN0_W      = 9;
    localparam int DELTA_W    = 20;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Band scaling 77/60 and the remainder step (1/256 Hz)
    localparam longint FREQ_STEP = 256000;
    localparam longint SCALE_NUM = 77;
    localparam longint SCALE_DEN = 60;
    localparam longint MOD2      = FREQ_STEP * SCALE_DEN;

    // Magnitudes of the dividends
    localparam longint A1_MAX = longint'(1) << (F_W - 1);
    localparam longint A2_MAX = A1_MAX * SCALE_NUM;
    localparam int     A1_W   = $clog2(A1_MAX + 1);
    localparam int     A2_W   = $clog2(A2_MAX + 1);
    localparam int     P2_W   = A2_W + 1;

    // Reciprocal constants: quotient estimate is low by at most one
    localparam int     RECIP_SH = 40;
    localparam longint K1       = (longint'(1) << RECIP_SH) / FREQ_STEP;
    localparam longint K2       = (longint'(1) << RECIP_SH) / MOD2;
    localparam int     K1_W     = $clog2(K1 + 1);
    localparam int     K2_W     = $clog2(K2 + 1);
    localparam int     Q1_W     = $clog2(A1_MAX / FREQ_STEP + 2);
    localparam int     Q2_W     = $clog2(A2_MAX / MOD2 + 2);

    // Partial and final remainders
    localparam int T1_W = $clog2(2 * FREQ_STEP);
    localparam int T2_W = $clog2(2 * MOD2);
    localparam int R1_W = $clog2(FREQ_STEP);
    localparam int R2_W = $clog2(MOD2);

    // Remainder error and thresholds, in 1/60 of the Doppler unit
    localparam int     ERR_W     = $clog2(2 * MOD2);
    localparam int     E_W       = ERR_W + 1;
    localparam longint DELTA_MAX = (longint'(1) << DELTA_W) - 1;
    localparam int     D60_W     = $clog2(DELTA_MAX * SCALE_DEN + 1);
    localparam int     D600_W    = $clog2(DELTA_MAX * SCALE_DEN * 10 + 1);

    // Register reset values
    localparam longint DELTA_RST = 2560;
    localparam longint LIMIT_RST = 10;
    localparam longint CN0_1_RST = 160;
    localparam longint CN0_2_RST = 140;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_DELTA    = 2'd0,
        CFG_MISMATCH_LIMIT = 2'd1,
        CFG_FIRST_CN0      = 2'd2,
        CFG_SECOND_CN0     = 2'd3
    } t_cfg_idx;

    // Register contents as seen by the datapath
    typedef struct packed {
        logic [D60_W-1:0]  delta60;
        logic [D600_W-1:0] delta600;
        logic [CNT_W-1:0]  limit;
        logic [CN0_W-1:0]  first_cn0;
        logic [CN0_W-1:0]  second_cn0;
    } t_cfg;

    // Item fields that ride along the Doppler pipeline
    typedef struct packed {
        logic             bit_edge_update;
        logic             channel_start;
        logic             external_xcorr;
        logic             first_band_present;
        logic             sensitivity_mode;
        logic             prn_check_fail;
        logic [CN0_W-1:0] second_band_cn0;
        logic [CN0_W-1:0] first_band_cn0;
    } t_ctrl;

    // Item handed from the Doppler pipeline to the decision stage
    typedef struct packed {
        t_ctrl            ctrl;
        logic [ERR_W-1:0] err;
    } t_err_item;

endpackage
`default_nettype wire

// ----- src/dccm_channels.sv -----
// Valid/ready channel interfaces for epoch items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface dccm_in_if;
    logic                            valid;
    logic                            ready;
    logic                            bit_edge_update;
    logic                            channel_start;
    logic                            external_xcorr;
    logic signed [dccm_pkg::F_W-1:0] second_band_freq;
    logic [dccm_pkg::CN0_W-1:0]      second_band_cn0;
    logic                            first_band_present;
    logic signed [dccm_pkg::F_W-1:0] first_band_freq;
    logic [dccm_pkg::CN0_W-1:0]      first_band_cn0;
    logic                            sensitivity_mode;
    logic                            prn_check_fail;

    modport source (
        output valid, bit_edge_update, channel_start, external_xcorr, second_band_freq,
               second_band_cn0, first_band_present, first_band_freq, first_band_cn0,
               sensitivity_mode, prn_check_fail,
        input  ready
    );
    modport sink (
        input  valid, bit_edge_update, channel_start, external_xcorr, second_band_freq,
               second_band_cn0, first_band_present, first_band_freq, first_band_cn0,
               sensitivity_mode, prn_check_fail,
        output ready
    );
endinterface

interface dccm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        xcorr_confirmed;
    logic                        suspect_request;
    logic                        sensitivity_echo;
    logic                        mismatch_now;
    logic [dccm_pkg::CNT_W-1:0]  mismatch_count;

    modport source (
        output valid, xcorr_confirmed, suspect_request, sensitivity_echo, mismatch_now,
               mismatch_count,
        input  ready
    );
    modport sink (
        input  valid, xcorr_confirmed, suspect_request, sensitivity_echo, mismatch_now,
               mismatch_count,
        output ready
    );
endinterface
`default_nettype wire

// ----- src/dccm_cfg.sv -----
// Configuration registers with precomputed match thresholds.
`timescale 1ns / 1ps
`default_nettype none
module dccm_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [dccm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [dccm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output dccm_pkg::t_cfg                           o_cfg
);

    logic [dccm_pkg::DELTA_W-1:0] v_delta;
    logic [dccm_pkg::D60_W-1:0]   n_delta60;
    logic [dccm_pkg::D600_W-1:0]  n_delta600;
    logic [dccm_pkg::D60_W-1:0]   r_delta60;
    logic [dccm_pkg::D600_W-1:0]  r_delta600;
    logic [dccm_pkg::CNT_W-1:0]   r_limit;
    logic [dccm_pkg::CN0_W-1:0]   r_first_cn0;
    logic [dccm_pkg::CN0_W-1:0]   r_second_cn0;

    // Scale the written delta once, so the datapath only compares
    always_comb begin
        v_delta    = i_cfg_wdata[dccm_pkg::DELTA_W-1:0];
        n_delta60  = dccm_pkg::D60_W'(v_delta) * dccm_pkg::D60_W'(dccm_pkg::SCALE_DEN);
        n_delta600 = dccm_pkg::D600_W'(v_delta) *
                     dccm_pkg::D600_W'(dccm_pkg::SCALE_DEN * 10);
    end

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta60    <= dccm_pkg::D60_W'(dccm_pkg::DELTA_RST * dccm_pkg::SCALE_DEN);
            r_delta600   <= dccm_pkg::D600_W'(dccm_pkg::DELTA_RST * dccm_pkg::SCALE_DEN * 10);
            r_limit      <= dccm_pkg::CNT_W'(dccm_pkg::LIMIT_RST);
            r_first_cn0  <= dccm_pkg::CN0_W'(dccm_pkg::CN0_1_RST);
            r_second_cn0 <= dccm_pkg::CN0_W'(dccm_pkg::CN0_2_RST);
        end else if (i_cfg_we) begin
            case (dccm_pkg::t_cfg_idx'(i_cfg_idx))
                dccm_pkg::CFG_MATCH_DELTA: begin
                    r_delta60  <= n_delta60;
                    r_delta600 <= n_delta600;
                end
                dccm_pkg::CFG_MISMATCH_LIMIT: begin
                    r_limit <= i_cfg_wdata[dccm_pkg::CNT_W-1:0];
                end
                dccm_pkg::CFG_FIRST_CN0: begin
                    r_first_cn0 <= i_cfg_wdata[dccm_pkg::CN0_W-1:0];
                end
                dccm_pkg::CFG_SECOND_CN0: begin
                    r_second_cn0 <= i_cfg_wdata[dccm_pkg::CN0_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.delta60    = r_delta60;
    assign o_cfg.delta600   = r_delta600;
    assign o_cfg.limit      = r_limit;
    assign o_cfg.first_cn0  = r_first_cn0;
    assign o_cfg.second_cn0 = r_second_cn0;

endmodule
`default_nettype wire

// ----- src/dccm_doppler_err.sv -----
// Pipelined Doppler remainder error: input register, reciprocal quotient, remainder, error.
`timescale 1ns / 1ps
`default_nettype none
module dccm_doppler_err (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    dccm_in_if.sink             i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output dccm_pkg::t_err_item o_item
);

    // Stage handshake
    logic ready0, ready1, ready2, ready3;
    logic r_v0, r_v1, r_v2, r_v3;

    // Stage 0: captured item
    dccm_pkg::t_ctrl                 r_ctrl0;
    logic signed [dccm_pkg::F_W-1:0] r_f1_0;
    logic signed [dccm_pkg::F_W-1:0] r_f2_0;

    // Stage 1: magnitudes and quotient estimates
    logic signed [dccm_pkg::P2_W-1:0]                    v_f2x;
    logic signed [dccm_pkg::P2_W-1:0]                    v_p2;
    logic                                                n_neg1, n_neg2;
    logic [dccm_pkg::A1_W-1:0]                           n_a1;
    logic [dccm_pkg::A2_W-1:0]                           n_a2;
    logic [dccm_pkg::A1_W+dccm_pkg::K1_W-1:0]            v_prod1;
    logic [dccm_pkg::A2_W+dccm_pkg::K2_W-1:0]            v_prod2;
    logic [dccm_pkg::Q1_W-1:0]                           n_q1;
    logic [dccm_pkg::Q2_W-1:0]                           n_q2;
    dccm_pkg::t_ctrl                                     r_ctrl1;
    logic                                                r_neg1_1, r_neg2_1;
    logic [dccm_pkg::A1_W-1:0]                           r_a1_1;
    logic [dccm_pkg::A2_W-1:0]                           r_a2_1;
    logic [dccm_pkg::Q1_W-1:0]                           r_q1_1;
    logic [dccm_pkg::Q2_W-1:0]                           r_q2_1;

    // Stage 2: partial remainders, below twice the step
    logic [dccm_pkg::T1_W-1:0] n_t1;
    logic [dccm_pkg::T2_W-1:0] n_t2;
    dccm_pkg::t_ctrl           r_ctrl2;
    logic                      r_neg1_2, r_neg2_2;
    logic [dccm_pkg::T1_W-1:0] r_t1_2;
    logic [dccm_pkg::T2_W-1:0] r_t2_2;

    // Stage 3: signed remainders and absolute error
    logic [dccm_pkg::R1_W-1:0]        v_r1u;
    logic [dccm_pkg::R2_W-1:0]        v_r2u;
    logic signed [dccm_pkg::E_W-1:0]  v_s1;
    logic signed [dccm_pkg::E_W-1:0]  v_s2;
    logic signed [dccm_pkg::E_W-1:0]  v_e;
    logic [dccm_pkg::ERR_W-1:0]       n_err;
    dccm_pkg::t_ctrl                  r_ctrl3;
    logic [dccm_pkg::ERR_W-1:0]       r_err3;

    // A stage takes a new item when it is empty or its item moves on
    assign ready3       = !r_v3 || i_ready;
    assign ready2       = !r_v2 || ready3;
    assign ready1       = !r_v1 || ready2;
    assign ready0       = !r_v0 || ready1;
    assign i_item.ready = ready0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready0) begin
                r_v0 <= i_item.valid;
            end
            if (ready1) begin
                r_v1 <= r_v0;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: scale the second band by 77, take magnitudes, estimate quotients
    always_comb begin
        v_f2x   = dccm_pkg::P2_W'(r_f2_0);
        v_p2    = v_f2x * dccm_pkg::P2_W'(dccm_pkg::SCALE_NUM);
        n_neg2  = v_p2[dccm_pkg::P2_W-1];
        n_a2    = dccm_pkg::A2_W'($unsigned(n_neg2 ? -v_p2 : v_p2));
        n_neg1  = r_f1_0[dccm_pkg::F_W-1];
        n_a1    = dccm_pkg::A1_W'($unsigned(n_neg1 ? -r_f1_0 : r_f1_0));
        v_prod1 = (dccm_pkg::A1_W + dccm_pkg::K1_W)'(n_a1) *
                  (dccm_pkg::A1_W + dccm_pkg::K1_W)'(dccm_pkg::K1);
        v_prod2 = (dccm_pkg::A2_W + dccm_pkg::K2_W)'(n_a2) *
                  (dccm_pkg::A2_W + dccm_pkg::K2_W)'(dccm_pkg::K2);
        n_q1    = dccm_pkg::Q1_W'(v_prod1 >> dccm_pkg::RECIP_SH);
        n_q2    = dccm_pkg::Q2_W'(v_prod2 >> dccm_pkg::RECIP_SH);
    end

    // Stage 2: subtract the estimated multiple of the step
    always_comb begin
        n_t1 = dccm_pkg::T1_W'(r_a1_1 -
               dccm_pkg::A1_W'(r_q1_1 * dccm_pkg::A1_W'(dccm_pkg::FREQ_STEP)));
        n_t2 = dccm_pkg::T2_W'(r_a2_1 -
               dccm_pkg::A2_W'(r_q2_1 * dccm_pkg::A2_W'(dccm_pkg::MOD2)));
    end

    // Stage 3: correct by one step, restore the dividend sign, form the error
    always_comb begin
        v_r1u = (r_t1_2 >= dccm_pkg::T1_W'(dccm_pkg::FREQ_STEP)) ?
                dccm_pkg::R1_W'(r_t1_2 - dccm_pkg::T1_W'(dccm_pkg::FREQ_STEP)) :
                dccm_pkg::R1_W'(r_t1_2);
        v_r2u = (r_t2_2 >= dccm_pkg::T2_W'(dccm_pkg::MOD2)) ?
                dccm_pkg::R2_W'(r_t2_2 - dccm_pkg::T2_W'(dccm_pkg::MOD2)) :
                dccm_pkg::R2_W'(r_t2_2);
        v_s1  = r_neg1_2 ? -$signed(dccm_pkg::E_W'(v_r1u)) : $signed(dccm_pkg::E_W'(v_r1u));
        v_s2  = r_neg2_2 ? -$signed(dccm_pkg::E_W'(v_r2u)) : $signed(dccm_pkg::E_W'(v_r2u));
        v_e   = v_s1 * $signed(dccm_pkg::E_W'(dccm_pkg::SCALE_DEN)) - v_s2;
        n_err = dccm_pkg::ERR_W'($unsigned(v_e[dccm_pkg::E_W-1] ? -v_e : v_e));
    end

    // Advance payloads along with their valid bits
    always_ff @(posedge i_clk) begin
        if (ready0) begin
            r_ctrl0.bit_edge_update    <= i_item.bit_edge_update;
            r_ctrl0.channel_start      <= i_item.channel_start;
            r_ctrl0.external_xcorr     <= i_item.external_xcorr;
            r_ctrl0.first_band_present <= i_item.first_band_present;
            r_ctrl0.sensitivity_mode   <= i_item.sensitivity_mode;
            r_ctrl0.prn_check_fail     <= i_item.prn_check_fail;
            r_ctrl0.second_band_cn0    <= i_item.second_band_cn0;
            r_ctrl0.first_band_cn0     <= i_item.first_band_cn0;
            r_f1_0                     <= i_item.first_band_freq;
            r_f2_0                     <= i_item.second_band_freq;
        end
        if (ready1) begin
            r_ctrl1  <= r_ctrl0;
            r_neg1_1 <= n_neg1;
            r_neg2_1 <= n_neg2;
            r_a1_1   <= n_a1;
            r_a2_1   <= n_a2;
            r_q1_1   <= n_q1;
            r_q2_1   <= n_q2;
        end
        if (ready2) begin
            r_ctrl2  <= r_ctrl1;
            r_neg1_2 <= r_neg1_1;
            r_neg2_2 <= r_neg2_1;
            r_t1_2   <= n_t1;
            r_t2_2   <= n_t2;
        end
        if (ready3) begin
            r_ctrl3 <= r_ctrl2;
            r_err3  <= n_err;
        end
    end

    assign o_valid     = r_v3;
    assign o_item.ctrl = r_ctrl3;
    assign o_item.err  = r_err3;

endmodule
`default_nettype wire

// ----- src/dccm_decide.sv -----
// Mismatch decision, whitelist marks, mismatch counter and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "doppler_cross_correlation_monitor_defines.svh"
module dccm_decide (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  dccm_pkg::t_err_item i_item,
    input  dccm_pkg::t_cfg      i_cfg,
    dccm_out_if.source          o_result
);

    logic v_take;

    // Kept state
    logic [dccm_pkg::CNT_W-1:0] r_cnt;
    logic                       r_fbw;
    logic                       r_sbw;
    logic                       r_conf;

    // State after an optional channel start
    logic [dccm_pkg::CNT_W-1:0] c_cnt;
    logic                       c_fbw, c_sbw, c_conf;

    // Next state and result
    logic [dccm_pkg::CNT_W-1:0] n_cnt;
    logic                       n_fbw, n_sbw, n_conf;
    logic                       n_mismatch, n_suspect, n_echo;

    // Result register
    logic                       r_out_valid;
    logic                       r_suspect, r_echo, r_mismatch;
    logic                       r_out_conf;
    logic [dccm_pkg::CNT_W-1:0] r_out_cnt;

    assign o_ready = !r_out_valid || o_result.ready;
    assign v_take  = i_valid && o_ready;

    // Judge the epoch and update marks and counter
    always_comb begin
        c_cnt  = i_item.ctrl.channel_start ? '0 : r_cnt;
        c_fbw  = i_item.ctrl.channel_start ? 1'b0 : r_fbw;
        c_sbw  = i_item.ctrl.channel_start ? 1'b0 : r_sbw;
        c_conf = i_item.ctrl.channel_start ? 1'b0 : r_conf;

        n_mismatch = i_item.ctrl.bit_edge_update && !i_item.ctrl.external_xcorr &&
                     i_item.ctrl.first_band_present &&
                     (dccm_pkg::D600_W'(i_item.err) > dccm_pkg::D600_W'(i_cfg.delta60)) &&
                     (dccm_pkg::D600_W'(i_item.err) >= i_cfg.delta600);

        n_cnt     = c_cnt;
        n_fbw     = c_fbw;
        n_sbw     = c_sbw;
        n_conf    = c_conf;
        n_suspect = 1'b0;
        n_echo    = 1'b0;

        if (i_item.ctrl.bit_edge_update) begin
            if (i_item.ctrl.external_xcorr) begin
                n_conf = 1'b1;
            end else begin
                if (i_item.ctrl.first_band_present) begin
                    n_fbw = i_item.ctrl.first_band_cn0 >= i_cfg.first_cn0;
                    n_sbw = i_item.ctrl.second_band_cn0 >= i_cfg.second_cn0;
                end
                if (i_item.ctrl.sensitivity_mode) begin
                    n_sbw = 1'b0;
                end
                if (n_mismatch) begin
                    if (c_cnt < i_cfg.limit) begin
                        n_cnt = c_cnt + 1'b1;
                    end else if (n_sbw && n_fbw) begin
                        n_conf = 1'b1;
                    end else if (!n_sbw && !n_fbw) begin
                        n_suspect = 1'b1;
                    end else if (!n_sbw) begin
                        n_conf = 1'b1;
                    end
                end else begin
                    n_cnt = '0;
                end
                n_suspect = n_suspect || i_item.ctrl.prn_check_fail;
                n_echo    = i_item.ctrl.sensitivity_mode;
            end
        end
    end

    // Commit state and hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_fbw       <= 1'b0;
            r_sbw       <= 1'b0;
            r_conf      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (v_take) begin
                r_cnt  <= n_cnt;
                r_fbw  <= n_fbw;
                r_sbw  <= n_sbw;
                r_conf <= n_conf;
            end
            if (v_take) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_take) begin
            r_out_conf <= n_conf;
            r_suspect  <= n_suspect;
            r_echo     <= n_echo;
            r_mismatch <= n_mismatch;
            r_out_cnt  <= n_cnt;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.xcorr_confirmed  = r_out_conf;
    assign o_result.suspect_request  = r_suspect;
    assign o_result.sensitivity_echo = r_echo;
    assign o_result.mismatch_now     = r_mismatch;
    assign o_result.mismatch_count   = r_out_cnt;

    // Counter moves only when an item is taken
    `DCCM_ASSERT_NEXT(a_cnt_hold, !v_take, $stable(r_cnt))
    // Confirmed mark stays set until a channel start
    `DCCM_ASSERT_NEXT(a_conf_sticky, v_take && !i_item.ctrl.channel_start && r_conf, r_conf)
    // A judged epoch without mismatch clears the counter
    `DCCM_ASSERT_NEXT(a_cnt_clear, v_take && i_item.ctrl.bit_edge_update && !i_item.ctrl.external_xcorr && !n_mismatch, r_cnt == '0)
    // A suspect request without a code failure needs a mismatch and no whitelist
    `DCCM_ASSERT_SAME(a_suspect_cause, v_take && n_suspect && !i_item.ctrl.prn_check_fail, n_mismatch && !n_fbw && !n_sbw)

endmodule
`default_nettype wire

// ----- src/doppler_cross_correlation_monitor.sv -----
// Doppler cross-correlation monitor: epoch items in, one result item per epoch out.
//
// Usage:
//   i_item carries one tracking epoch (bit-edge flag, channel start, external flag,
//   both band Dopplers and CN0s, sensitivity mode, code check flag). o_result returns
//   one item per epoch: confirmed mark, suspect request, sensitivity echo, this
//   epoch's mismatch and the consecutive mismatch count. Both use valid/ready. Users
//   write registers via i_cfg_we / i_cfg_idx / i_cfg_wdata only if idle; unenforced.
// Pipeline and throughput:
//   The Doppler path is a four-stage pipeline (input register, reciprocal quotient
//   multiply, remainder multiply-subtract, correction and error) ahead of the
//   decision stage, so one item is taken per cycle while o_result is not stalled;
//   the per-channel state updates in the decision stage as each item enters the
//   result register.
// Reset:
//   Synchronous, active low. Registers return to their defaults, all marks and the
//   counter clear, and the pipeline empties.
// Stall:
//   A result held on o_result keeps its value; the pipeline keeps filling its empty
//   stages and i_item.ready drops only when every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none
module doppler_cross_correlation_monitor (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    dccm_in_if.sink                              i_item,
    dccm_out_if.source                           o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [dccm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dccm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    dccm_pkg::t_cfg      cfg;
    dccm_pkg::t_err_item err_item;
    logic                err_valid;
    logic                err_ready;

    // Configuration registers
    dccm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Doppler remainder error pipeline
    dccm_doppler_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (err_valid),
        .i_ready (err_ready),
        .o_item  (err_item)
    );

    // Decision, state and result register
    dccm_decide u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (err_valid),
        .o_ready  (err_ready),
        .i_item   (err_item),
        .i_cfg    (cfg),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
